// ===== rtl/linear_recurrence_generator_top_defines.svh =====
// assertion macros for the linear recurrence generator
// used by linear_recurrence_generator_top; no other dependencies
`ifndef LINEAR_RECURRENCE_GENERATOR_TOP_DEFINES_SVH
`define LINEAR_RECURRENCE_GENERATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// expression must hold at every clock edge out of reset
`define LRG_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("lrg assertion failed");
// antecedent implies consequent in the same cycle
`define LRG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lrg assertion failed");
// antecedent implies consequent in the next cycle
`define LRG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lrg assertion failed");
`else
`define LRG_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define LRG_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LRG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/lrg_pkg.sv =====
// types and constants of the linear recurrence generator
// no dependencies; used by linear_recurrence_generator_top
`default_nettype none

package lrg_pkg;

	// action codes
	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_PUSH = 2'd1;
	localparam logic [1:0] ACT_GEN  = 2'd2;

	// Q16.16 one and saturation limits
	localparam logic signed [31:0] ONE_Q16  = 32'sh0001_0000;
	localparam logic signed [31:0] TERM_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] TERM_MIN = 32'sh8000_0000;

	// rounding offset at bit 15
	localparam int unsigned RND_HALF = 32768;

	typedef struct packed {
		logic [1:0]          action;
		logic [2:0]          coef_index;
		logic signed [31:0]  value;
	} in_t;

	typedef struct packed {
		logic signed [31:0]  term;
		logic                overflow;
	} out_t;

endpackage

`default_nettype wire

// ===== rtl/linear_recurrence_generator_top.sv =====
// K-th order linear recurrence generator: a(n) = c1*a(n-1)+...+cK*a(n-K)+c(K+1)
// Input items load coefficients, push seed terms or request the next term.
// Two valid/ready channels, in_data (lrg_pkg::in_t) and out_data (lrg_pkg::out_t).
// History and coefficients sit in two small synchronous memories; one shared
// multiplier walks the taps, one tap per cycle, into a wide accumulator.
// Load: no result. Push seed: the seed is echoed with overflow 0. Unused action
// code: no result, no state change. Generate: the tap loop makes ORDER+1
// memory reads through read, multiply and accumulate stages, then the
// round and saturate step sets the result; one item is worked on at a time.
// The result sits in an output register, so a load or a generate is taken
// while a result waits; a push waits until the output register is free.
// When the receiver stalls, a finished term is held until the output frees.
// Reset clears the control state and marks every history and coefficient
// entry as zero through per-entry valid bits; no clearing pass is needed.
// includes linear_recurrence_generator_top_defines.svh, uses lrg_pkg
`default_nettype none

`include "linear_recurrence_generator_top_defines.svh"

module linear_recurrence_generator_top #(
	parameter int ORDER = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire lrg_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output lrg_pkg::out_t      out_data
);

	localparam int CW    = $clog2(ORDER + 1);
	localparam int HW    = (ORDER > 1) ? $clog2(ORDER) : 1;
	localparam int IW    = (CW > 3) ? CW : 3;
	localparam int ACC_W = 64 + $clog2(ORDER + 1);
	localparam int RW    = ACC_W - 16;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	state_t state_q;

	// memories and their per-entry valid bits
	logic signed [31:0] hist_mem [ORDER];
	logic signed [31:0] coef_mem [ORDER + 1];
	logic [ORDER-1:0]   hist_vld_q;
	logic [ORDER:0]     coef_vld_q;

	logic [HW-1:0] wp_q;
	logic [HW-1:0] rp_q;
	logic [CW-1:0] cnt_q;

	// tap pipeline
	logic               v_s1, last_s1, const_s1, hvld_s1, cvld_s1;
	logic signed [31:0] hist_rd_s1, coef_rd_s1;
	logic               v_s2, last_s2;
	logic signed [63:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;

	logic          out_valid_q;
	lrg_pkg::out_t out_q;

	logic               in_xfer, out_free;
	logic               is_load, is_push, is_gen, load_ok, fin_go;
	logic [IW-1:0]      idx_ext;
	logic [HW-1:0]      newest;
	logic               hist_we;
	logic signed [31:0] hist_wd;
	logic signed [31:0] a_mul, b_mul;
	logic signed [ACC_W-1:0] rnd;
	logic signed [RW-1:0]    r_full;
	logic               sat;
	logic signed [31:0] fin_term;

	// handshake and decode
	assign out_free = !out_valid_q || out_ready;
	assign is_load  = (in_data.action == lrg_pkg::ACT_LOAD);
	assign is_push  = (in_data.action == lrg_pkg::ACT_PUSH);
	assign is_gen   = (in_data.action == lrg_pkg::ACT_GEN);
	assign in_ready = (state_q == ST_IDLE) && (!is_push || out_free);
	assign in_xfer  = in_valid && in_ready;
	assign idx_ext  = IW'(in_data.coef_index);
	assign load_ok  = (idx_ext <= IW'(ORDER));
	assign newest   = (wp_q == '0) ? HW'(ORDER - 1) : wp_q - HW'(1);
	assign fin_go   = (state_q == ST_FIN) && out_free;

	// history write: seed push or finished term
	assign hist_we = (in_xfer && is_push) || fin_go;
	assign hist_wd = fin_go ? fin_term : in_data.value;

	// multiplier operands, unwritten entries read as zero
	assign a_mul = cvld_s1 ? coef_rd_s1 : 32'sd0;
	assign b_mul = const_s1 ? lrg_pkg::ONE_Q16 : (hvld_s1 ? hist_rd_s1 : 32'sd0);

	// round half up at bit 15, then saturate to 32 bits
	assign rnd      = acc_q + ACC_W'(lrg_pkg::RND_HALF);
	assign r_full   = rnd[ACC_W-1:16];
	assign sat      = !((&r_full[RW-1:31]) || !(|r_full[RW-1:31]));
	assign fin_term = sat ? (r_full[RW-1] ? lrg_pkg::TERM_MIN : lrg_pkg::TERM_MAX)
	                      : r_full[31:0];

	// history memory, one write and one read port
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[wp_q] <= hist_wd;
		end
		hist_rd_s1 <= hist_mem[rp_q];
	end

	// coefficient memory, one write and one read port
	always_ff @(posedge clk) begin
		if (in_xfer && is_load && load_ok) begin
			coef_mem[CW'(idx_ext)] <= in_data.value;
		end
		coef_rd_s1 <= coef_mem[cnt_q];
	end

	// multiply stage
	always_ff @(posedge clk) begin
		prod_s2 <= a_mul * b_mul;
	end

	// control: sequencer, pointers, valid bits, accumulator and output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hist_vld_q  <= '0;
			coef_vld_q  <= '0;
			wp_q        <= '0;
			rp_q        <= '0;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			last_s1     <= 1'b0;
			const_s1    <= 1'b0;
			hvld_s1     <= 1'b0;
			cvld_s1     <= 1'b0;
			v_s2        <= 1'b0;
			last_s2     <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// read stage tags follow the issued tap
			v_s1     <= (state_q == ST_RUN);
			last_s1  <= (state_q == ST_RUN) && (cnt_q == CW'(ORDER));
			const_s1 <= (cnt_q == CW'(ORDER));
			hvld_s1  <= hist_vld_q[rp_q];
			cvld_s1  <= coef_vld_q[cnt_q];
			v_s2     <= v_s1;
			last_s2  <= last_s1;

			if (in_xfer && is_load && load_ok) begin
				coef_vld_q[CW'(idx_ext)] <= 1'b1;
			end
			if (hist_we) begin
				hist_vld_q[wp_q] <= 1'b1;
				wp_q <= (wp_q == HW'(ORDER - 1)) ? '0 : wp_q + HW'(1);
			end

			// accumulate products
			if (in_xfer && is_gen) begin
				acc_q <= '0;
			end else if (v_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer && is_gen) begin
						cnt_q   <= '0;
						rp_q    <= newest;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					// one tap read per cycle, newest history term first
					rp_q  <= (rp_q == '0) ? HW'(ORDER - 1) : rp_q - HW'(1);
					if (cnt_q == CW'(ORDER)) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_DRAIN: begin
					if (last_s2) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// output register
			if (fin_go) begin
				out_valid_q    <= 1'b1;
				out_q.term     <= fin_term;
				out_q.overflow <= sat;
			end else if (in_xfer && is_push) begin
				out_valid_q    <= 1'b1;
				out_q.term     <= in_data.value;
				out_q.overflow <= 1'b0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks on the sequencer and tap pipeline
	`LRG_ASSERT_IMPLY(a_busy_no_ready, clk, arst_n, state_q != ST_IDLE, !in_ready)
	`LRG_ASSERT_IMPLY(a_last_in_drain, clk, arst_n, last_s2, state_q == ST_DRAIN)
	`LRG_ASSERT_IMPLY(a_tap_in_gen, clk, arst_n, v_s2, state_q == ST_RUN || state_q == ST_DRAIN)
	`LRG_ASSERT_NEXT(a_fin_emits, clk, arst_n, fin_go, out_valid && state_q == ST_IDLE)

endmodule

`default_nettype wire
